FILE: hdl/cht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 24;
    localparam int CODE_W   = 16;
    localparam int WT_W     = 20;
    localparam int STATUS_W = 3;

    localparam int DEF_BUCKETS = 16;
    localparam int DEF_ENTRIES = 64;

    // hash word id*7+3, padded to whole digits of the remainder unit
    localparam int DIG_W      = 4;
    localparam int HASH_W     = 28;
    localparam int HASH_STEPS = HASH_W / DIG_W;
    localparam int STEP_W     = $clog2(HASH_STEPS);

    localparam int QUEUE_DEPTH = 4;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FOUND    = 3'd1,
        ST_MISS     = 3'd2,
        ST_DELETED  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_W-1:0]   package_id;
        logic [CODE_W-1:0] sender_code;
        logic [CODE_W-1:0] destination_code;
        logic [WT_W-1:0]   weight_centi;
    } req_t;

    localparam int REQ_BITS = $bits(req_t);

endpackage

FILE: hdl/cht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/cht_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module cht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cht_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/cht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_front
// Takes requests, hashes the id to a bucket and hands them to the queue.
// ----------------------------------------------------------------------------
module cht_front #(
    parameter int BUCKETS = cht_pkg::DEF_BUCKETS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  cht_pkg::req_t                           req_in,
    output logic                                    q_wr,
    output logic [cht_pkg::REQ_BITS+$clog2(BUCKETS)-1:0] q_data,
    input  logic                                    q_full
);

    localparam int  BKT_W = $clog2(BUCKETS);
    localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic                          stg_valid_reg, stg_valid_next;
    logic                          busy_reg, busy_next;
    cht_pkg::req_t                 item_reg, item_next;
    logic [cht_pkg::HASH_W-1:0]    hash_reg, hash_next;
    logic [BKT_W-1:0]              rem_reg, rem_next;
    logic [cht_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [cht_pkg::HASH_W-1:0]    hash_in;
    logic [BKT_W-1:0]              rem_step;
    logic [BKT_W:0]                trial;
    logic                          accept;

    // id*7 + 3
    assign hash_in = (cht_pkg::HASH_W'(req_in.package_id) << 3)
                   - cht_pkg::HASH_W'(req_in.package_id) + cht_pkg::HASH_W'(3);

    assign q_wr   = stg_valid_reg && !busy_reg && !q_full;
    assign full   = stg_valid_reg && !q_wr;
    assign accept = push && !full;
    assign q_data = {item_reg, rem_reg};

    // one digit of restoring remainder per pass, four bits per cycle
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < cht_pkg::DIG_W; i++)
        begin
            trial = {rem_step, hash_reg[cht_pkg::HASH_W-1-i]};
            if (trial >= (BKT_W+1)'(BUCKETS))
            begin
                trial = trial - (BKT_W+1)'(BUCKETS);
            end
            rem_step = trial[BKT_W-1:0];
        end
    end

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        busy_next      = busy_reg;
        item_next      = item_reg;
        hash_next      = hash_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        if (q_wr)
        begin
            stg_valid_next = 1'b0;
        end
        if (busy_reg)
        begin
            hash_next = hash_reg << cht_pkg::DIG_W;
            rem_next  = rem_step;
            step_next = step_reg + 1'b1;
            if (step_reg == cht_pkg::STEP_W'(cht_pkg::HASH_STEPS-1))
            begin
                busy_next = 1'b0;
            end
        end
        if (accept)
        begin
            stg_valid_next = 1'b1;
            item_next      = req_in;
            hash_next      = hash_in;
            step_next      = '0;
            if (POW2)
            begin
                rem_next  = hash_in[BKT_W-1:0];
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = '0;
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

FILE: hdl/cht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_back
// Carries out inserts, searches and deletes on the chained node store.
// ----------------------------------------------------------------------------
module cht_back #(
    parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
    parameter int ENTRIES = cht_pkg::DEF_ENTRIES
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_valid,
    input  logic [cht_pkg::REQ_BITS+$clog2(BUCKETS)-1:0] q_data,
    output logic                                         q_rd,
    output logic                                         empty,
    input  logic                                         pop,
    output logic [cht_pkg::STATUS_W-1:0]                 status,
    output logic [$clog2(BUCKETS)-1:0]                   bucket,
    output logic [cht_pkg::CODE_W-1:0]                   found_sender,
    output logic [cht_pkg::CODE_W-1:0]                   found_destination,
    output logic [cht_pkg::WT_W-1:0]                     found_weight
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int PTR_W  = IDX_W + 1;
    localparam int DATA_W = cht_pkg::ID_W + 2 * cht_pkg::CODE_W + cht_pkg::WT_W;
    localparam int NODE_W = PTR_W + DATA_W;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HEAD  = 4'b0100,
        S_NODE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [BKT_W-1:0]    clr_reg, clr_next;
    cht_pkg::req_t       item_reg, item_next;
    logic [BKT_W-1:0]    bkt_reg, bkt_next;
    logic [PTR_W-1:0]    cur_reg, cur_next;
    logic [PTR_W-1:0]    prev_reg, prev_next;
    logic [DATA_W-1:0]   prev_data_reg, prev_data_next;
    logic [PTR_W-1:0]    sp_reg, sp_next;
    logic [PTR_W-1:0]    fresh_reg, fresh_next;

    logic                      out_valid_reg, out_valid_next;
    cht_pkg::status_t          out_status_reg, out_status_next;
    logic [cht_pkg::CODE_W-1:0] out_snd_reg, out_snd_next;
    logic [cht_pkg::CODE_W-1:0] out_dst_reg, out_dst_next;
    logic [cht_pkg::WT_W-1:0]  out_wt_reg, out_wt_next;
    logic [BKT_W-1:0]          out_bkt_reg, out_bkt_next;

    logic               head_we;
    logic [BKT_W-1:0]   head_waddr;
    logic [PTR_W-1:0]   head_wdata, head_rdata;
    logic               node_we;
    logic [IDX_W-1:0]   node_waddr, node_raddr;
    logic [NODE_W-1:0]  node_wdata, node_rdata;
    logic               stk_we;
    logic [IDX_W-1:0]   stk_rdata;

    cht_pkg::req_t      q_item;
    logic [BKT_W-1:0]   q_bkt;
    logic [PTR_W-1:0]   rd_link;
    logic [cht_pkg::ID_W-1:0]   rd_key;
    logic [cht_pkg::CODE_W-1:0] rd_snd, rd_dst;
    logic [cht_pkg::WT_W-1:0]   rd_wt;
    logic [IDX_W-1:0]   new_node;

    assign {q_item, q_bkt} = q_data;
    assign {rd_link, rd_key, rd_snd, rd_dst, rd_wt} = node_rdata;
    assign new_node = (sp_reg != '0) ? stk_rdata : fresh_reg[IDX_W-1:0];

    cht_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (q_bkt),
        .rdata (head_rdata)
    );

    cht_ram #(.WIDTH(NODE_W), .DEPTH(ENTRIES)) u_node (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // stack of returned nodes; never-used nodes come from fresh_reg
    cht_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sp_reg[IDX_W-1:0]),
        .wdata (cur_reg[IDX_W-1:0]),
        .raddr (IDX_W'(sp_reg - 1'b1)),
        .rdata (stk_rdata)
    );

    assign empty             = !out_valid_reg;
    assign status            = out_status_reg;
    assign bucket            = out_bkt_reg;
    assign found_sender      = out_snd_reg;
    assign found_destination = out_dst_reg;
    assign found_weight      = out_wt_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        item_next       = item_reg;
        bkt_next        = bkt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_data_next  = prev_data_reg;
        sp_next         = sp_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_snd_next    = out_snd_reg;
        out_dst_next    = out_dst_reg;
        out_wt_next     = out_wt_reg;
        out_bkt_next    = out_bkt_reg;
        q_rd            = 1'b0;
        head_we         = 1'b0;
        head_waddr      = bkt_reg;
        head_wdata      = NIL;
        node_we         = 1'b0;
        node_waddr      = new_node;
        node_wdata      = {head_rdata, item_reg.package_id, item_reg.sender_code,
                           item_reg.destination_code, item_reg.weight_centi};
        node_raddr      = rd_link[IDX_W-1:0];
        stk_we          = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(BUCKETS-1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_rd       = 1'b1;
                    item_next  = q_item;
                    bkt_next   = q_bkt;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                out_valid_next  = 1'b1;
                out_bkt_next    = bkt_reg;
                out_status_next = cht_pkg::ST_MISS;
                out_snd_next    = '0;
                out_dst_next    = '0;
                out_wt_next     = '0;
                state_next      = S_IDLE;
                node_raddr      = head_rdata[IDX_W-1:0];
                case (item_reg.req_type) inside
                    cht_pkg::REQ_INSERT:
                    begin
                        if (sp_reg == '0 && fresh_reg == NIL)
                        begin
                            out_status_next = cht_pkg::ST_FULL;
                        end
                        else
                        begin
                            node_we         = 1'b1;
                            head_we         = 1'b1;
                            head_wdata      = {1'b0, new_node};
                            out_status_next = cht_pkg::ST_INSERTED;
                            if (sp_reg != '0)
                            begin
                                sp_next = sp_reg - 1'b1;
                            end
                            else
                            begin
                                fresh_next = fresh_reg + 1'b1;
                            end
                        end
                    end
                    cht_pkg::REQ_SEARCH, cht_pkg::REQ_DELETE:
                    begin
                        if (head_rdata != NIL)
                        begin
                            out_valid_next = out_valid_reg && !pop;
                            cur_next       = head_rdata;
                            prev_next      = NIL;
                            state_next     = S_NODE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_NODE:
            begin
                if (rd_key == item_reg.package_id)
                begin
                    out_valid_next = 1'b1;
                    out_bkt_next   = bkt_reg;
                    out_snd_next   = '0;
                    out_dst_next   = '0;
                    out_wt_next    = '0;
                    state_next     = S_IDLE;
                    if (item_reg.req_type == cht_pkg::REQ_SEARCH)
                    begin
                        out_status_next = cht_pkg::ST_FOUND;
                        out_snd_next    = rd_snd;
                        out_dst_next    = rd_dst;
                        out_wt_next     = rd_wt;
                    end
                    else
                    begin
                        out_status_next = cht_pkg::ST_DELETED;
                        // unlink: predecessor is either the bucket head or a node
                        if (prev_reg == NIL)
                        begin
                            head_we    = 1'b1;
                            head_wdata = rd_link;
                        end
                        else
                        begin
                            node_we    = 1'b1;
                            node_waddr = prev_reg[IDX_W-1:0];
                            node_wdata = {rd_link, prev_data_reg};
                        end
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_data_next = node_rdata[DATA_W-1:0];
                    cur_next       = rd_link;
                    if (rd_link == NIL)
                    begin
                        out_valid_next  = 1'b1;
                        out_bkt_next    = bkt_reg;
                        out_status_next = cht_pkg::ST_MISS;
                        out_snd_next    = '0;
                        out_dst_next    = '0;
                        out_wt_next     = '0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_data_reg  <= prev_data_next;
        out_status_reg <= out_status_next;
        out_snd_reg    <= out_snd_next;
        out_dst_reg    <= out_dst_next;
        out_wt_reg     <= out_wt_next;
        out_bkt_reg    <= out_bkt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/chained_hash_table_top.sv
`timescale 1ns / 1ps
// Path: front, queue, back. The front hashes at once for power-of-two BUCKETS,
// else in the remainder unit (4 bits a cycle); the back reads the bucket head
// in S_HEAD, each chain node walked in S_NODE. It takes a new request only
// once the last result is popped; the front takes none while hashing.
// Reset: async, active low; back clears the bucket heads one by one after
// reset, requests queue up meanwhile.
// ----------------------------------------------------------------------------
// chained_hash_table_top
// Hash table of package records with separate chaining and a free pool.
// ----------------------------------------------------------------------------
module chained_hash_table_top #(
    parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
    parameter int ENTRIES = cht_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [cht_pkg::REQ_W-1:0]       req_type,
    input  logic [cht_pkg::ID_W-1:0]        package_id,
    input  logic [cht_pkg::CODE_W-1:0]      sender_code,
    input  logic [cht_pkg::CODE_W-1:0]      destination_code,
    input  logic [cht_pkg::WT_W-1:0]        weight_centi,
    output logic                            empty,
    input  logic                            pop,
    output logic [cht_pkg::STATUS_W-1:0]    status,
    output logic [$clog2(BUCKETS)-1:0]      bucket,
    output logic [cht_pkg::CODE_W-1:0]      found_sender,
    output logic [cht_pkg::CODE_W-1:0]      found_destination,
    output logic [cht_pkg::WT_W-1:0]        found_weight
);

    localparam int Q_W = cht_pkg::REQ_BITS + $clog2(BUCKETS);

    cht_pkg::req_t   req_in;
    logic            fq_wr, fq_full, fq_rd, fq_valid;
    logic [Q_W-1:0]  fq_wdata, fq_rdata;

    assign req_in = '{req_type:         req_type,
                      package_id:       package_id,
                      sender_code:      sender_code,
                      destination_code: destination_code,
                      weight_centi:     weight_centi};

    cht_front #(.BUCKETS(BUCKETS)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .req_in (req_in),
        .q_wr   (fq_wr),
        .q_data (fq_wdata),
        .q_full (fq_full)
    );

    cht_fifo #(.WIDTH(Q_W), .DEPTH(cht_pkg::QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_wr),
        .wr_data (fq_wdata),
        .full    (fq_full),
        .rd_en   (fq_rd),
        .valid   (fq_valid),
        .rd_data (fq_rdata)
    );

    cht_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (fq_valid),
        .q_data            (fq_rdata),
        .q_rd              (fq_rd),
        .empty             (empty),
        .pop               (pop),
        .status            (status),
        .bucket            (bucket),
        .found_sender      (found_sender),
        .found_destination (found_destination),
        .found_weight      (found_weight)
    );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the chained hash table against a behavioral table model: directed
// table, pool fill and overflow, then random insert/search/delete
// traffic (some of unused type) with random idling on both queue sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BUCKETS   = cht_pkg::DEF_BUCKETS;
    localparam int ENTRIES   = cht_pkg::DEF_ENTRIES;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int NUM_RAND  = 1460;
    localparam int WDOG_MAX  = 20000;
    localparam logic [2:0] NO_CHECK = 3'd7;
    localparam logic [cht_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [cht_pkg::STATUS_W-1:0] status;
        logic [BKT_W-1:0]             bucket;
        logic [cht_pkg::CODE_W-1:0]   snd;
        logic [cht_pkg::CODE_W-1:0]   dst;
        logic [cht_pkg::WT_W-1:0]     wt;
    } answer_t;

    typedef struct {
        cht_pkg::req_t rq;
        logic [2:0]    fixed_st;   // NO_CHECK when predictor alone decides
    } row_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [cht_pkg::REQ_W-1:0]    req_type;
    logic [cht_pkg::ID_W-1:0]     package_id;
    logic [cht_pkg::CODE_W-1:0]   sender_code;
    logic [cht_pkg::CODE_W-1:0]   destination_code;
    logic [cht_pkg::WT_W-1:0]     weight_centi;
    logic empty;
    logic pop;
    logic [cht_pkg::STATUS_W-1:0] status;
    logic [BKT_W-1:0]             bucket;
    logic [cht_pkg::CODE_W-1:0]   found_sender;
    logic [cht_pkg::CODE_W-1:0]   found_destination;
    logic [cht_pkg::WT_W-1:0]     found_weight;

    chained_hash_table_top i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .package_id(package_id), .sender_code(sender_code),
        .destination_code(destination_code), .weight_centi(weight_centi),
        .empty(empty), .pop(pop), .status(status), .bucket(bucket),
        .found_sender(found_sender), .found_destination(found_destination),
        .found_weight(found_weight)
    );

    // table model state
    int unsigned                head_of[BUCKETS];
    int unsigned                next_of[ENTRIES];
    logic [cht_pkg::ID_W-1:0]   key_of[ENTRIES];
    logic [cht_pkg::CODE_W-1:0] snd_of[ENTRIES];
    logic [cht_pkg::CODE_W-1:0] dst_of[ENTRIES];
    logic [cht_pkg::WT_W-1:0]   wt_of[ENTRIES];
    int unsigned                free_nodes[ENTRIES];
    int unsigned                free_cnt;
    logic [cht_pkg::ID_W-1:0]   live_ids[$];

    answer_t pending_answers[$];
    int      mismatches;
    int      accepted;
    bit      quiet_phase;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [BKT_W-1:0] hash_bucket(logic [cht_pkg::ID_W-1:0] id);
        logic [31:0] h;
        h = 32'(id) * 32'd7 + 32'd3;
        return h[BKT_W-1:0];
    endfunction

    function automatic answer_t table_apply(cht_pkg::req_t rq);
        answer_t a;
        int unsigned cur, prv, n;
        a = '0;
        a.bucket = hash_bucket(rq.package_id);
        a.status = cht_pkg::ST_MISS;
        if (rq.req_type == cht_pkg::REQ_INSERT)
        begin
            if (free_cnt == 0)
            begin
                a.status = cht_pkg::ST_FULL;
            end
            else
            begin
                free_cnt--;
                n = free_nodes[free_cnt];
                key_of[n] = rq.package_id;
                snd_of[n] = rq.sender_code;
                dst_of[n] = rq.destination_code;
                wt_of[n] = rq.weight_centi;
                next_of[n] = head_of[a.bucket];
                head_of[a.bucket] = n;
                a.status = cht_pkg::ST_INSERTED;
                live_ids.push_back(rq.package_id);
            end
        end
        else if (rq.req_type == cht_pkg::REQ_SEARCH || rq.req_type == cht_pkg::REQ_DELETE)
        begin
            cur = head_of[a.bucket];
            prv = ENTRIES;
            for (int s = 0; s < ENTRIES && cur < ENTRIES; s++)
            begin
                if (key_of[cur] == rq.package_id)
                begin
                    if (rq.req_type == cht_pkg::REQ_SEARCH)
                    begin
                        a.status = cht_pkg::ST_FOUND;
                        a.snd = snd_of[cur];
                        a.dst = dst_of[cur];
                        a.wt = wt_of[cur];
                    end
                    else
                    begin
                        if (prv < ENTRIES) next_of[prv] = next_of[cur];
                        else head_of[a.bucket] = next_of[cur];
                        free_nodes[free_cnt] = cur;
                        free_cnt++;
                        a.status = cht_pkg::ST_DELETED;
                    end
                    break;
                end
                prv = cur;
                cur = next_of[cur];
            end
        end
        return a;
    endfunction

    task automatic send_request(cht_pkg::req_t rq, logic [2:0] fixed_st);
        answer_t a;
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req_type <= rq.req_type;
        package_id <= rq.package_id;
        sender_code <= rq.sender_code;
        destination_code <= rq.destination_code;
        weight_centi <= rq.weight_centi;
        @(posedge clk);
        while (full) @(posedge clk);
        a = table_apply(rq);
        // typed-in status is what the block must answer
        if (fixed_st != NO_CHECK)
            a.status = fixed_st;
        pending_answers.push_back(a);
    endtask

    function automatic cht_pkg::req_t rand_request();
        cht_pkg::req_t rq;
        int pick;
        rq.sender_code = 16'($urandom);
        rq.destination_code = 16'($urandom);
        rq.weight_centi = 20'($urandom);
        pick = $urandom_range(0, 99);
        // mostly small ids so chains collide and repeat
        rq.package_id = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 40));
        if (live_ids.size() > 0 && $urandom_range(0, 1) == 1)
            rq.package_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        if (pick < 40) rq.req_type = cht_pkg::REQ_INSERT;
        else if (pick < 70) rq.req_type = cht_pkg::REQ_SEARCH;
        else if (pick < 97) rq.req_type = cht_pkg::REQ_DELETE;
        else rq.req_type = REQ_UNUSED;
        return rq;
    endfunction

    // result side
    initial
    begin
        answer_t e;
        int gap;
        pop = 1'b0;
        mismatches = 0;
        accepted = 0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 19);
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty)
            begin
                accepted++;
                if (pending_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: status %0d bucket %0d",
                                 status, bucket);
                end
                else
                begin
                    e = pending_answers.pop_front();
                    if (status !== e.status || bucket !== e.bucket
                        || found_sender !== e.snd || found_destination !== e.dst
                        || found_weight !== e.wt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st %0d b %0d s %h d %h w %h, ",
                                      "got st %0d b %0d s %h d %h w %h"},
                                     e.status, e.bucket, e.snd, e.dst, e.wt,
                                     status, bucket, found_sender,
                                     found_destination, found_weight);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any accepted transaction
    initial
    begin
        int idle;
        int last;
        idle = 0;
        last = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || accepted != last) idle = 0;
            else idle++;
            last = accepted;
            if (idle >= WDOG_MAX)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows[$];
        cht_pkg::req_t rq;
        int settle;
        push = 1'b0;
        req_type = '0;
        package_id = '0;
        sender_code = '0;
        destination_code = '0;
        weight_centi = '0;
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        for (int i = 0; i < BUCKETS; i++) head_of[i] = ENTRIES;
        for (int i = 0; i < ENTRIES; i++) free_nodes[i] = i;
        free_cnt = ENTRIES;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        rows.push_back('{'{cht_pkg::REQ_SEARCH, 24'h0, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_MISS});
        rows.push_back('{'{cht_pkg::REQ_DELETE, 24'hFFFFFF, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_MISS});
        rows.push_back('{'{cht_pkg::REQ_INSERT, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                           20'hFFFFF}, cht_pkg::ST_INSERTED});
        rows.push_back('{'{cht_pkg::REQ_INSERT, 24'h0, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_INSERTED});
        rows.push_back('{'{cht_pkg::REQ_SEARCH, 24'hFFFFFF, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_FOUND});
        rows.push_back('{'{cht_pkg::REQ_SEARCH, 24'h0, 16'hFFFF, 16'hFFFF, 20'hFFFFF},
                         cht_pkg::ST_FOUND});
        // same bucket as id 0: chain of three, newest duplicate wins
        rows.push_back('{'{cht_pkg::REQ_INSERT, 24'h10, 16'h1234, 16'h5678, 20'h12345},
                         cht_pkg::ST_INSERTED});
        rows.push_back('{'{cht_pkg::REQ_INSERT, 24'h10, 16'hAAAA, 16'h5555, 20'hAAAAA},
                         cht_pkg::ST_INSERTED});
        rows.push_back('{'{cht_pkg::REQ_SEARCH, 24'h10, 16'h0, 16'h0, 20'h0},
                         NO_CHECK});
        rows.push_back('{'{cht_pkg::REQ_DELETE, 24'h0, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_DELETED});
        rows.push_back('{'{cht_pkg::REQ_DELETE, 24'h10, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_DELETED});
        rows.push_back('{'{cht_pkg::REQ_SEARCH, 24'h10, 16'h0, 16'h0, 20'h0},
                         NO_CHECK});
        rows.push_back('{'{cht_pkg::REQ_SEARCH, 24'h0, 16'h0, 16'h0, 20'h0},
                         cht_pkg::ST_MISS});
        rows.push_back('{'{REQ_UNUSED, 24'h123456, 16'hFFFF, 16'hFFFF, 20'hFFFFF},
                         cht_pkg::ST_MISS});
        foreach (rows[i]) send_request(rows[i].rq, rows[i].fixed_st);

        // fill the pool, overflow it, then delete each id in live_ids
        while (free_cnt > 0)
        begin
            rq = '{cht_pkg::REQ_INSERT, 24'($urandom), 16'($urandom), 16'($urandom),
                   20'($urandom)};
            send_request(rq, cht_pkg::ST_INSERTED);
        end
        rq = '{cht_pkg::REQ_INSERT, 24'h000001, 16'h1, 16'h1, 20'h1};
        send_request(rq, cht_pkg::ST_FULL);
        while (live_ids.size() > 0)
        begin
            rq = '{cht_pkg::REQ_DELETE, live_ids.pop_front(), 16'h0, 16'h0, 20'h0};
            send_request(rq, NO_CHECK);
        end

        for (int i = 0; i < NUM_RAND; i++)
        begin
            if (i == NUM_RAND - 200) quiet_phase = 1'b1;
            rq = rand_request();
            if (rq.req_type == cht_pkg::REQ_DELETE && live_ids.size() > 0
                && $urandom_range(0, 1) == 1)
                rq.package_id = live_ids.pop_front();
            send_request(rq, NO_CHECK);
        end
        push <= 1'b0;

        settle = 0;
        while (pending_answers.size() > 0 && settle < WDOG_MAX)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (2 * ENTRIES + 20) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: chained_hash_table_top.f
hdl/cht_pkg.sv
hdl/cht_ram.sv
hdl/cht_fifo.sv
hdl/cht_front.sv
hdl/cht_back.sv
hdl/chained_hash_table_top.sv
bench/testbench.sv
